/* design/frwm_pkg.sv */
// frwm_pkg: shared types, widths and constants of the frame rate window meter.
// Used by frame_rate_window_meter_top and frwm_sva; no dependencies.
`timescale 1ns / 1ps

package frwm_pkg;

   // Default sizing handed to the top level
   localparam int HISTORY_DEPTH_DEF      = 64;
   localparam int RATE_FRACTION_BITS_DEF = 8;

   // Fixed field widths
   localparam int TS_W       = 48;
   localparam int INTERVAL_W = 32;
   localparam int FRAMES_W   = 32;
   localparam int SUM_W      = 33;
   localparam int RATE_W     = 28;
   localparam int ENTRIES_W  = 7;
   localparam int CFG_W      = 32;

   // One second in microseconds, and its width
   localparam int                US_W          = 20;
   localparam logic [US_W-1:0]   US_PER_SECOND = US_W'(1_000_000);
   localparam logic [CFG_W-1:0]  WINDOW_RESET  = CFG_W'(1_000_000);

   // Command codes on req_tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // Register map: word index taken from paddr above the byte offset
   localparam int   CSR_ADDR_W     = 3;
   localparam logic CSR_IDX_WINDOW = 1'b0;

   // Stream layouts
   localparam int REQ_TDATA_W = 48;

   localparam int RSP_INTERVAL_LSB = 0;
   localparam int RSP_ELAPSED_LSB  = RSP_INTERVAL_LSB + INTERVAL_W;
   localparam int RSP_FRAMES_LSB   = RSP_ELAPSED_LSB + TS_W;
   localparam int RSP_INSTANT_LSB  = RSP_FRAMES_LSB + FRAMES_W;
   localparam int RSP_AVERAGE_LSB  = RSP_INSTANT_LSB + RATE_W;
   localparam int RSP_ENTRIES_LSB  = RSP_AVERAGE_LSB + RATE_W;
   localparam int RSP_USED_W       = RSP_ENTRIES_LSB + ENTRIES_W;
   localparam int RSP_TDATA_W      = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W        = RSP_TDATA_W - RSP_USED_W;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ELAPSED,
      ST_DROP_RD,
      ST_DROP_SUB,
      ST_PUSH,
      ST_TRIM,
      ST_INST_GO,
      ST_INST_WAIT,
      ST_MUL,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_DONE
   } frwm_state_type;

endpackage

/* design/frwm_div.sv */
// frwm_div: restoring radix-2 divider, one quotient bit per cycle.
// Standalone; instantiated by frame_rate_window_meter_top.
`timescale 1ns / 1ps

module frwm_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             fits;

   // Shift in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      fits  = ~diff[DEN_W+1];
   end

   // Step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend register turns into the quotient as bits shift through
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

/* design/frame_rate_window_meter_top.sv */
// frame_rate_window_meter_top: sliding-window frame rate meter, top level.
// Depends on frwm_pkg and frwm_div.
//
//   port group   dir   kind        carries
//   req_*        in    stream      tuser: cmd; tdata: timestamp_us
//   rsp_*        out   stream      tdata: interval, elapsed, frames, rates, entries
//   csr_*        in    APB write   window_us at byte address 0
//
// One item at a time (NUM_W, the dividend width, is 35 by default). A start goes from
// idle straight to done; a frame steps through difference, elapsed, push and trim, a drop
// (a registered read of the history RAM, then the subtract) per interval shed, a full
// history shedding its oldest first, then divides, each skipped on zero interval or empty.
// req_tready is high only while idle; a finished result waits in the output register
// while the next item is taken. Synchronous reset; the history RAM needs no clearing.
`timescale 1ns / 1ps

module frame_rate_window_meter_top #(
   parameter int HISTORY_DEPTH      = frwm_pkg::HISTORY_DEPTH_DEF,
   parameter int RATE_FRACTION_BITS = frwm_pkg::RATE_FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [frwm_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [47:0] timestamp_us
   input  logic                               req_tuser,   // [0] cmd
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] interval_us, [79:32] elapsed_us, [111:80] frames_seen,
   // [139:112] instant_rate_q8, [167:140] average_rate_q8,
   // [174:168] window_entries, [175] zero
   output logic [frwm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [frwm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [frwm_pkg::CFG_W-1:0]         csr_pwdata,
   output logic [frwm_pkg::CFG_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   localparam int AW      = $clog2(HISTORY_DEPTH);
   localparam int CW      = $clog2(HISTORY_DEPTH + 1);
   localparam int TS_W    = frwm_pkg::TS_W;
   localparam int IV_W    = frwm_pkg::INTERVAL_W;
   localparam int SUM_W   = frwm_pkg::SUM_W;
   localparam int RATE_W  = frwm_pkg::RATE_W;
   localparam int ONE_W   = frwm_pkg::US_W + RATE_FRACTION_BITS;
   localparam int NUM_RAW = ONE_W + CW;
   localparam int NUM_W   = (NUM_RAW > RATE_W) ? NUM_RAW : RATE_W + 1;
   localparam logic [NUM_W-1:0] RATE_ONE =
      NUM_W'(frwm_pkg::US_PER_SECOND) << RATE_FRACTION_BITS;

   frwm_pkg::frwm_state_type state_ff, state_in;

   // control and model state
   logic [TS_W-1:0]               start_time_ff;
   logic [TS_W-1:0]               last_time_ff;
   logic [frwm_pkg::FRAMES_W-1:0] frame_total_ff;
   logic [AW-1:0]                 head_ff;
   logic [CW-1:0]                 count_ff;
   logic [SUM_W-1:0]              sum_ff;
   logic                          pushed_ff;
   logic [frwm_pkg::CFG_W-1:0]    window_ff;
   logic                          rsp_valid_ff;

   // payload
   logic [TS_W-1:0]                  ts_ff;
   logic [IV_W-1:0]                  interval_ff;
   logic [TS_W-1:0]                  elapsed_ff;
   logic [RATE_W-1:0]                inst_ff;
   logic [RATE_W-1:0]                avg_ff;
   logic [NUM_W-1:0]                 numer_ff;
   logic [frwm_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // history RAM
   logic [IV_W-1:0] fifo_mem [HISTORY_DEPTH];
   logic [IV_W-1:0] rd_data_ff;

   // sequencer outputs
   logic ready;
   logic div_start;
   logic mem_we;
   logic rsp_load;

   logic [TS_W-1:0]  diff;
   logic [AW:0]      tail_sum;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    head_next;
   logic             fifo_full;
   logic             over_window;
   logic [NUM_W-1:0] div_numer;
   logic [SUM_W-1:0] div_denom;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;
   logic [RATE_W-1:0] quot_sat;
   logic             cfg_write;
   logic             csr_hit;

   // ---------------------------------------------------------------
   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[frwm_pkg::CSR_ADDR_W-1:2] == frwm_pkg::CSR_IDX_WINDOW);
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit;
   assign csr_prdata = csr_hit ? window_ff : '0;

   // ---------------------------------------------------------------
   // Datapath helpers
   always_comb begin
      diff        = ts_ff - last_time_ff;
      tail_sum    = (AW+1)'(head_ff) + (AW+1)'(count_ff);
      wr_addr     = (tail_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(tail_sum);
      head_next   = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + AW'(1);
      fifo_full   = (count_ff == CW'(HISTORY_DEPTH));
      over_window = (sum_ff > {1'b0, window_ff}) && (count_ff != '0);
      quot_sat    = (|div_quot[NUM_W-1:RATE_W]) ? '1 : div_quot[RATE_W-1:0];
   end

   // Divider operands: instant rate uses the interval, average uses the sum
   always_comb begin
      if (state_ff == frwm_pkg::ST_AVG_GO) begin
         div_numer = numer_ff;
         div_denom = sum_ff;
      end else begin
         div_numer = RATE_ONE;
         div_denom = SUM_W'(interval_ff);
      end
   end

   frwm_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ---------------------------------------------------------------
   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frwm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == frwm_pkg::CMD_START) ?
                          frwm_pkg::ST_DONE : frwm_pkg::ST_DIFF;
            end
         end
         frwm_pkg::ST_DIFF:     state_in = frwm_pkg::ST_ELAPSED;
         frwm_pkg::ST_ELAPSED: begin
            state_in = fifo_full ? frwm_pkg::ST_DROP_RD : frwm_pkg::ST_PUSH;
         end
         frwm_pkg::ST_DROP_RD:  state_in = frwm_pkg::ST_DROP_SUB;
         frwm_pkg::ST_DROP_SUB: begin
            state_in = pushed_ff ? frwm_pkg::ST_TRIM : frwm_pkg::ST_PUSH;
         end
         frwm_pkg::ST_PUSH:     state_in = frwm_pkg::ST_TRIM;
         frwm_pkg::ST_TRIM: begin
            state_in = over_window ? frwm_pkg::ST_DROP_RD : frwm_pkg::ST_INST_GO;
         end
         frwm_pkg::ST_INST_GO: begin
            state_in = (interval_ff != '0) ? frwm_pkg::ST_INST_WAIT : frwm_pkg::ST_MUL;
         end
         frwm_pkg::ST_INST_WAIT: begin
            if (div_done) state_in = frwm_pkg::ST_MUL;
         end
         frwm_pkg::ST_MUL:      state_in = frwm_pkg::ST_AVG_GO;
         frwm_pkg::ST_AVG_GO: begin
            state_in = (count_ff != '0 && sum_ff != '0) ?
                       frwm_pkg::ST_AVG_WAIT : frwm_pkg::ST_DONE;
         end
         frwm_pkg::ST_AVG_WAIT: begin
            if (div_done) state_in = frwm_pkg::ST_DONE;
         end
         frwm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = frwm_pkg::ST_IDLE;
         end
         default:               state_in = frwm_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: control outputs
   always_comb begin
      ready     = 1'b0;
      div_start = 1'b0;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         frwm_pkg::ST_IDLE:     ready = 1'b1;
         frwm_pkg::ST_PUSH:     mem_we = 1'b1;
         frwm_pkg::ST_INST_GO:  div_start = (interval_ff != '0);
         frwm_pkg::ST_AVG_GO:   div_start = (count_ff != '0) && (sum_ff != '0);
         frwm_pkg::ST_DONE:     rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   assign req_tready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frwm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Meter state, window register and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff  <= '0;
         last_time_ff   <= '0;
         frame_total_ff <= '0;
         head_ff        <= '0;
         count_ff       <= '0;
         sum_ff         <= '0;
         pushed_ff      <= 1'b0;
         window_ff      <= frwm_pkg::WINDOW_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cfg_write) window_ff <= csr_pwdata;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            frwm_pkg::ST_IDLE: begin
               pushed_ff <= 1'b0;
               if (req_tvalid && req_tuser == frwm_pkg::CMD_START) begin
                  start_time_ff  <= req_tdata[TS_W-1:0];
                  last_time_ff   <= req_tdata[TS_W-1:0];
                  frame_total_ff <= '0;
                  head_ff        <= '0;
                  count_ff       <= '0;
                  sum_ff         <= '0;
               end
            end
            frwm_pkg::ST_DIFF: begin
               last_time_ff   <= ts_ff;
               frame_total_ff <= frame_total_ff + frwm_pkg::FRAMES_W'(1);
            end
            frwm_pkg::ST_DROP_SUB: begin
               sum_ff   <= sum_ff - SUM_W'(rd_data_ff);
               head_ff  <= head_next;
               count_ff <= count_ff - CW'(1);
            end
            frwm_pkg::ST_PUSH: begin
               sum_ff    <= sum_ff + SUM_W'(interval_ff);
               count_ff  <= count_ff + CW'(1);
               pushed_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Per-item payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         frwm_pkg::ST_IDLE: begin
            ts_ff <= req_tdata[TS_W-1:0];
            if (req_tvalid && req_tuser == frwm_pkg::CMD_START) begin
               interval_ff <= '0;
               elapsed_ff  <= '0;
               inst_ff     <= '0;
               avg_ff      <= '0;
            end
         end
         frwm_pkg::ST_DIFF: begin
            // saturate the 48-bit difference to 32 bits
            interval_ff <= (|diff[TS_W-1:IV_W]) ? '1 : diff[IV_W-1:0];
         end
         frwm_pkg::ST_ELAPSED:   elapsed_ff <= ts_ff - start_time_ff;
         frwm_pkg::ST_INST_GO: begin
            if (interval_ff == '0) inst_ff <= '0;
         end
         frwm_pkg::ST_INST_WAIT: begin
            if (div_done) inst_ff <= quot_sat;
         end
         frwm_pkg::ST_MUL:       numer_ff <= RATE_ONE * NUM_W'(count_ff);
         frwm_pkg::ST_AVG_GO: begin
            if (count_ff == '0 || sum_ff == '0) avg_ff <= '0;
         end
         frwm_pkg::ST_AVG_WAIT: begin
            if (div_done) avg_ff <= quot_sat;
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {{frwm_pkg::RSP_PAD_W{1'b0}},
                         frwm_pkg::ENTRIES_W'(count_ff),
                         avg_ff,
                         inst_ff,
                         frame_total_ff,
                         elapsed_ff,
                         interval_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------
   // History RAM: one write port, one registered read at the head
   always_ff @(posedge clock) begin
      if (mem_we) fifo_mem[wr_addr] <= interval_ff;
      rd_data_ff <= fifo_mem[head_ff];
   end

endmodule

/* design/frwm_checker.sv */
// frwm_sva: port-level checks on frame_rate_window_meter_top, bound to it.
// Depends on frwm_pkg.
`timescale 1ns / 1ps

module frwm_sva #(
   parameter int HISTORY_DEPTH = frwm_pkg::HISTORY_DEPTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [frwm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [frwm_pkg::INTERVAL_W-1:0] interval;
   logic [frwm_pkg::RATE_W-1:0]     instant;
   logic [frwm_pkg::RATE_W-1:0]     average;
   logic [frwm_pkg::ENTRIES_W-1:0]  entries;

   assign interval = rsp_tdata[frwm_pkg::RSP_INTERVAL_LSB +: frwm_pkg::INTERVAL_W];
   assign instant  = rsp_tdata[frwm_pkg::RSP_INSTANT_LSB +: frwm_pkg::RATE_W];
   assign average  = rsp_tdata[frwm_pkg::RSP_AVERAGE_LSB +: frwm_pkg::RATE_W];
   assign entries  = rsp_tdata[frwm_pkg::RSP_ENTRIES_LSB +: frwm_pkg::ENTRIES_W];

   // a stalled result holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // only one item in flight: input closes right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after a transfer");

   // zero interval gives zero instant rate
   a_inst_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && interval == '0 |-> instant == '0)
      else $error("instant rate nonzero for zero interval");

   // empty window gives zero average rate
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      (HISTORY_DEPTH < 128) && rsp_tvalid && entries == '0 |-> average == '0)
      else $error("average rate nonzero for empty window");

   // leaving reset: no result pending, input open
   a_reset_exit: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind frame_rate_window_meter_top frwm_sva #(
   .HISTORY_DEPTH (HISTORY_DEPTH)
) u_frwm_sva (.*);
